### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared widths, codes and the entry and command types of the cell chain.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH   = 16;
   localparam int ELEM_W  = 32;
   localparam int PRI_W   = 8;
   localparam int CAP_W   = 5;
   localparam int COUNT_W = 5;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_DELETE = 1'b1
   } func_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] value;
      logic        [PRI_W-1:0]  pri;
   } entry_type;

   // broadcast to every cell in the chain
   typedef struct packed {
      logic      ins;
      logic      del;
      entry_type fresh;
   } cmd_type;

endpackage

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted list: keeps its entry, takes the new word, or
// shifts in from the left (insert) or from the right (delete).
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic               clock,
   input  spq_pkg::cmd_type   cmd,
   input  logic               live,
   input  logic               left_ge,
   input  spq_pkg::entry_type left_entry,
   input  spq_pkg::entry_type right_entry,
   output spq_pkg::entry_type entry,
   output logic               ge
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // live entries with priority >= the new one form a prefix of the chain
   assign ge    = live && (entry_ff.pri >= cmd.fresh.pri);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.del) begin
         entry_in = right_entry;
      end else if (cmd.ins && !ge) begin
         if (left_ge) begin
            entry_in = cmd.fresh;
         end else begin
            entry_in = left_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins || cmd.del) begin
         entry_ff <= entry_in;
      end
   end

endmodule

### rtl/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted priority queue core
// A result is registered in the cycle after its word is accepted.
// Throughput: one insert or delete per cycle while results are taken; every
// cell of the chain compares and shifts in the same cycle, and the result
// register frees as soon as its word is taken.
// Reset: count cleared, capacity back to 16, no result pending; slot
// contents are left as they are.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [spq_pkg::CAP_W-1:0]           csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic signed [spq_pkg::ELEM_W-1:0]   req_element,
   input  logic [spq_pkg::PRI_W-1:0]           req_priority_req,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic signed [spq_pkg::ELEM_W-1:0]   rsp_removed_element,
   output logic [spq_pkg::PRI_W-1:0]           rsp_removed_priority,
   output logic [spq_pkg::COUNT_W-1:0]         rsp_count
);

   localparam int DEPTH = spq_pkg::DEPTH;
   localparam int CNT_W = spq_pkg::CNT_W;
   localparam int CMP_W = spq_pkg::CMP_W;

   logic [spq_pkg::CAP_W-1:0]         capacity_ff;
   logic [CNT_W-1:0]                  count_ff;
   logic [CNT_W-1:0]                  count_in;
   logic                              rsp_valid_ff;
   spq_pkg::status_type               rsp_status_ff;
   spq_pkg::status_type               status_in;
   logic signed [spq_pkg::ELEM_W-1:0] rsp_element_ff;
   logic [spq_pkg::PRI_W-1:0]         rsp_priority_ff;
   logic [spq_pkg::COUNT_W-1:0]       rsp_count_ff;

   logic                              accept;
   logic                              is_delete;
   logic [CMP_W-1:0]                  cap_ext;
   logic [CMP_W-1:0]                  eff_cap;
   logic                              full;
   logic                              empty;
   spq_pkg::cmd_type                  cmd;

   spq_pkg::entry_type                cell_entry [DEPTH];
   spq_pkg::entry_type                left_entry [DEPTH];
   spq_pkg::entry_type                right_entry [DEPTH];
   logic [DEPTH-1:0]                  cell_ge;
   logic [DEPTH-1:0]                  left_ge;
   logic [DEPTH-1:0]                  live;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_delete = (req_func == spq_pkg::FUNC_DELETE);

   assign cap_ext = CMP_W'(capacity_ff);
   assign eff_cap = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
   assign full    = CMP_W'(count_ff) >= eff_cap;
   assign empty   = (count_ff == '0);

   always_comb begin
      cmd.ins         = accept && !is_delete && !full;
      cmd.del         = accept && is_delete && !empty;
      cmd.fresh.value = req_element;
      cmd.fresh.pri   = req_priority_req;
   end

   always_comb begin
      count_in  = count_ff;
      status_in = spq_pkg::STATUS_OK;
      if (is_delete) begin
         if (empty) begin
            status_in = spq_pkg::STATUS_UNDERFLOW;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end else begin
         if (full) begin
            status_in = spq_pkg::STATUS_OVERFLOW;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         assign live[gi] = CNT_W'(gi) < count_ff;

         if (gi == 0) begin : g_head
            assign left_ge[gi]    = 1'b1;
            assign left_entry[gi] = cmd.fresh;
         end else begin : g_body
            assign left_ge[gi]    = cell_ge[gi-1];
            assign left_entry[gi] = cell_entry[gi-1];
         end

         if (gi == DEPTH - 1) begin : g_tail
            assign right_entry[gi] = cell_entry[gi];
         end else begin : g_inner
            assign right_entry[gi] = cell_entry[gi+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .live        (live[gi]),
            .left_ge     (left_ge[gi]),
            .left_entry  (left_entry[gi]),
            .right_entry (right_entry[gi]),
            .entry       (cell_entry[gi]),
            .ge          (cell_ge[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= spq_pkg::CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload: head word on a good delete, zero otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status_in;
         rsp_count_ff  <= spq_pkg::COUNT_W'(count_in);
         if (cmd.del) begin
            rsp_element_ff  <= cell_entry[0].value;
            rsp_priority_ff <= cell_entry[0].pri;
         end else begin
            rsp_element_ff  <= '0;
            rsp_priority_ff <= '0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_removed_element  = rsp_element_ff;
   assign rsp_removed_priority = rsp_priority_ff;
   assign rsp_count            = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("entry count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the count");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.del |=> count_ff == $past(count_ff) - 1'b1)
      else $error("delete did not shrink the count");

   a_underflow: assert property (@(posedge clock) disable iff (reset)
      accept && is_delete && empty |=> rsp_status_ff == spq_pkg::STATUS_UNDERFLOW)
      else $error("delete on empty queue not flagged");

   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != spq_pkg::STATUS_OK |->
         rsp_element_ff == '0 && rsp_priority_ff == '0)
      else $error("failed operation returned a word");
`endif

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert and delete words into the core and checks every result
// against a behavioral copy of the queue. The copy keeps its own sorted slot
// list, live count and capacity, and predicts each result as the word is
// accepted. Directed tests cover empty and full cases, extreme values and
// ties; random phases move the capacity around and fill and drain the queue
// while both sides stall at random, but for one steady phase.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 12;
   localparam int PHASE_WORDS = 154;

   typedef struct {
      spq_pkg::status_type                status;
      logic signed [spq_pkg::ELEM_W-1:0]  element;
      logic [spq_pkg::PRI_W-1:0]          pri;
      logic [spq_pkg::COUNT_W-1:0]        count;
   } queue_result_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_wr_en = 1'b0;
   logic [spq_pkg::CAP_W-1:0]         csr_wr_data = '0;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic                              req_func = 1'b0;
   logic signed [spq_pkg::ELEM_W-1:0] req_element = '0;
   logic [spq_pkg::PRI_W-1:0]         req_priority_req = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [1:0]                        rsp_status;
   logic signed [spq_pkg::ELEM_W-1:0] rsp_removed_element;
   logic [spq_pkg::PRI_W-1:0]         rsp_removed_priority;
   logic [spq_pkg::COUNT_W-1:0]       rsp_count;

   // behavioral copy of the queue
   logic signed [spq_pkg::ELEM_W-1:0] slot_value [spq_pkg::DEPTH];
   logic [spq_pkg::PRI_W-1:0]         slot_pri [spq_pkg::DEPTH];
   int                                held_entries = 0;
   logic [spq_pkg::CAP_W-1:0]         capacity_reg = spq_pkg::CAP_RESET;

   queue_result_type pending_results [$];
   int               error_count = 0;
   int               cycle_count = 0;
   logic             steady = 1'b0;

   sorted_priority_queue_core dut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_element          (req_element),
      .req_priority_req     (req_priority_req),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_removed_element  (rsp_removed_element),
      .rsp_removed_priority (rsp_removed_priority),
      .rsp_count            (rsp_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 31);
   end

   function automatic queue_result_type apply_queue_op(
         spq_pkg::func_type op,
         logic signed [spq_pkg::ELEM_W-1:0] val,
         logic [spq_pkg::PRI_W-1:0] pri);
      queue_result_type r;
      int               pos;
      int               limit;
      r.status  = spq_pkg::STATUS_OK;
      r.element = '0;
      r.pri     = '0;
      limit = (capacity_reg > spq_pkg::DEPTH) ? spq_pkg::DEPTH : int'(capacity_reg);
      if (op == spq_pkg::FUNC_INSERT) begin
         if (held_entries >= limit) begin
            r.status = spq_pkg::STATUS_OVERFLOW;
         end else begin
            // place behind every entry of greater or equal priority
            pos = 0;
            while (pos < held_entries && slot_pri[pos] >= pri) pos++;
            for (int i = held_entries; i > pos; i--) begin
               slot_value[i] = slot_value[i-1];
               slot_pri[i]   = slot_pri[i-1];
            end
            slot_value[pos] = val;
            slot_pri[pos]   = pri;
            held_entries++;
         end
      end else begin
         if (held_entries == 0) begin
            r.status = spq_pkg::STATUS_UNDERFLOW;
         end else begin
            r.element = slot_value[0];
            r.pri     = slot_pri[0];
            for (int i = 1; i < held_entries; i++) begin
               slot_value[i-1] = slot_value[i];
               slot_pri[i-1]   = slot_pri[i];
            end
            held_entries--;
         end
      end
      r.count = spq_pkg::COUNT_W'(held_entries);
      return r;
   endfunction

   // check the result word first, then predict the word accepted at this edge
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result word with no expectation pending");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_removed_element !== want.element) begin
                  $error("removed_element: expected %0d, actual %0d",
                         want.element, rsp_removed_element);
                  error_count++;
               end
               if (rsp_removed_priority !== want.pri) begin
                  $error("removed_priority: expected %0d, actual %0d",
                         want.pri, rsp_removed_priority);
                  error_count++;
               end
               if (rsp_count !== want.count) begin
                  $error("count: expected %0d, actual %0d", want.count, rsp_count);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_results.push_back(apply_queue_op(spq_pkg::func_type'(req_func),
                                                     req_element, req_priority_req));
         end
      end
   end

   task automatic send_word(spq_pkg::func_type op,
                            logic signed [spq_pkg::ELEM_W-1:0] val,
                            logic [spq_pkg::PRI_W-1:0] pri);
      if (!steady && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= op;
      req_element      <= val;
      req_priority_req <= pri;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait until every expected result has been taken
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_capacity(logic [spq_pkg::CAP_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      capacity_reg = value;
   endtask

   task automatic test_empty_and_extremes();
      send_word(spq_pkg::FUNC_DELETE, 32'sh1234_5678, 8'hAA);
      send_word(spq_pkg::FUNC_INSERT, 32'sh7FFF_FFFF, 8'd0);
      send_word(spq_pkg::FUNC_INSERT, 32'sh8000_0000, 8'd255);
      send_word(spq_pkg::FUNC_INSERT, -32'sd1, 8'd128);
      send_word(spq_pkg::FUNC_INSERT, 32'sd0, 8'd128);
      repeat (4) send_word(spq_pkg::FUNC_DELETE, -32'sd1, 8'hFF);
      send_word(spq_pkg::FUNC_DELETE, 32'sd0, 8'd0);
      drain_results();
   endtask

   task automatic test_equal_priorities();
      send_word(spq_pkg::FUNC_INSERT, 32'sd10, 8'd5);
      send_word(spq_pkg::FUNC_INSERT, 32'sd11, 8'd9);
      send_word(spq_pkg::FUNC_INSERT, 32'sd12, 8'd5);
      send_word(spq_pkg::FUNC_INSERT, 32'sd13, 8'd5);
      repeat (4) send_word(spq_pkg::FUNC_DELETE, 32'sd0, 8'd0);
      drain_results();
   endtask

   task automatic test_capacity_limits();
      write_capacity(spq_pkg::CAP_W'(0));
      send_word(spq_pkg::FUNC_INSERT, 32'sd21, 8'd1);
      drain_results();
      write_capacity(spq_pkg::CAP_W'(2));
      send_word(spq_pkg::FUNC_INSERT, 32'sd22, 8'd1);
      send_word(spq_pkg::FUNC_INSERT, 32'sd23, 8'd2);
      send_word(spq_pkg::FUNC_INSERT, 32'sd24, 8'd3);
      drain_results();
      // capacity now below the count: entries stay, inserts overflow
      write_capacity(spq_pkg::CAP_W'(1));
      send_word(spq_pkg::FUNC_INSERT, 32'sd25, 8'd4);
      send_word(spq_pkg::FUNC_DELETE, 32'sd0, 8'd0);
      send_word(spq_pkg::FUNC_DELETE, 32'sd0, 8'd0);
      send_word(spq_pkg::FUNC_INSERT, 32'sd26, 8'd6);
      drain_results();
   endtask

   task automatic test_random_traffic();
      logic [spq_pkg::CAP_W-1:0]         cap;
      logic signed [spq_pkg::ELEM_W-1:0] val;
      logic [spq_pkg::PRI_W-1:0]         pri;
      spq_pkg::func_type                 op;
      int                                insert_pct;
      bit                                narrow;
      for (int phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(9))
            0:       cap = spq_pkg::CAP_W'(0);
            1:       cap = spq_pkg::CAP_W'(31);
            2:       cap = spq_pkg::CAP_W'(17);
            3:       cap = spq_pkg::CAP_W'(16);
            4:       cap = spq_pkg::CAP_W'(1);
            default: cap = spq_pkg::CAP_W'($urandom_range(1, 16));
         endcase
         if (phase == PHASES - 1) cap = spq_pkg::CAP_W'(16);
         write_capacity(cap);
         narrow = phase[0];
         steady = (phase == 5);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // alternate fill and drain bursts so the queue swings end to end
            insert_pct = ((n / 40) % 2 == 0) ? 80 : 25;
            op = ($urandom_range(99) < insert_pct) ? spq_pkg::FUNC_INSERT
                                                   : spq_pkg::FUNC_DELETE;
            val = $urandom;
            if ($urandom_range(19) == 0) begin
               val = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            end
            pri = narrow ? spq_pkg::PRI_W'($urandom_range(0, 3))
                         : spq_pkg::PRI_W'($urandom_range(0, 255));
            if ($urandom_range(19) == 0) pri = $urandom_range(1) ? 8'd255 : 8'd0;
            send_word(op, val, pri);
         end
         drain_results();
         steady = 1'b0;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_extremes();
      test_equal_priorities();
      test_capacity_limits();
      test_random_traffic();
      repeat (4) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
